// ===== design/lbc_pkg.sv =====
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types and codes for the block cache.
// ----------------------------------------------------------------------------
package lbc_pkg;

  localparam logic [1:0] StatusHit    = 2'd0;
  localparam logic [1:0] StatusMiss   = 2'd1;
  localparam logic [1:0] StatusInsert = 2'd2;

  localparam logic KindLookup = 1'b0;
  localparam logic KindInsert = 1'b1;

  typedef struct packed {
    logic       start;
    logic       want_match;
    logic       want_free;
    logic       want_oldest;
  } scan_ctrl_t;

  typedef struct packed {
    logic       done;
    logic       found;
  } scan_stat_t;

endpackage

// ===== design/lbc_scan.sv =====
// ----------------------------------------------------------------------------
// lbc_scan
// Sequential tag scan: one entry a cycle through the shared compare unit.
// Finds a matching entry, the lowest free entry and the oldest stamp together.
// ----------------------------------------------------------------------------
module lbc_scan #(
  parameter int unsigned ENTRIES = 64,
  parameter int unsigned IW      = $clog2(ENTRIES)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [IW:0]         limit_i,
  input  logic [39:0]         key_i,
  input  logic                ent_valid_i,
  input  logic [39:0]         ent_tag_i,
  input  logic [63:0]         ent_stamp_i,
  output logic [IW-1:0]       addr_o,
  output logic                busy_o,
  output logic                done_o,
  output logic                match_o,
  output logic [IW-1:0]       match_idx_o,
  output logic                free_o,
  output logic [IW-1:0]       free_idx_o,
  output logic [IW-1:0]       old_idx_o
);

  logic [IW:0]   cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          rd_q, rd_d;
  logic [IW-1:0] ridx_q;
  logic          match_q, match_d, free_q, free_d, done_q, done_d;
  logic [IW-1:0] midx_q, midx_d, fidx_q, fidx_d, oidx_q, oidx_d;
  logic [63:0]   ostamp_q, ostamp_d;
  logic          first_q, first_d;

  assign addr_o = cnt_q[IW-1:0];

  always_comb begin
    cnt_d = cnt_q; busy_d = busy_q; rd_d = 1'b0;
    match_d = match_q; free_d = free_q; midx_d = midx_q; fidx_d = fidx_q;
    oidx_d = oidx_q; ostamp_d = ostamp_q; first_d = first_q; done_d = 1'b0;
    if (start_i) begin
      cnt_d = '0; busy_d = 1'b1; match_d = 1'b0; free_d = 1'b0; first_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q < limit_i) begin
        rd_d  = 1'b1;
        cnt_d = cnt_q + 1'b1;
      end else if (!rd_q) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
    if (rd_q) begin
      if (ent_valid_i && ent_tag_i == key_i && !match_q) begin
        match_d = 1'b1; midx_d = ridx_q;
      end
      if (!ent_valid_i && !free_q) begin
        free_d = 1'b1; fidx_d = ridx_q;
      end
      if (first_q || ent_stamp_i < ostamp_q) begin
        oidx_d = ridx_q; ostamp_d = ent_stamp_i;
      end
      first_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; busy_q <= 1'b0; rd_q <= 1'b0; done_q <= 1'b0;
      match_q <= 1'b0; free_q <= 1'b0; first_q <= 1'b1;
    end else begin
      cnt_q <= cnt_d; busy_q <= busy_d; rd_q <= rd_d; done_q <= done_d;
      match_q <= match_d; free_q <= free_d; first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= cnt_q[IW-1:0];
    midx_q <= midx_d; fidx_q <= fidx_d; oidx_q <= oidx_d; ostamp_q <= ostamp_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign match_o = match_q;
  assign match_idx_o = midx_q;
  assign free_o = free_q;
  assign free_idx_o = fidx_q;
  assign old_idx_o = oidx_q;

  a_rd_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_q |-> $past(busy_q)) else $error("scan read outside scan");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("scan done while busy");
  a_cnt_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q <= limit_i) else $error("scan count past limit");

endmodule

// ===== design/lru_block_cache_top.sv =====
// ----------------------------------------------------------------------------
// lru_block_cache_top
// Fully associative block cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// A lookup or an insert of word 0 scans the active tag entries one a cycle
// through a shared compare unit. After the scan a lookup miss goes to S_RESP,
// a hit to S_STREAM and an insert of word 0 through S_WRITE and S_RESP. A hit
// streams BLOCK_WORDS words from the data memory, one a cycle while the output
// does not stall. Later insert words skip the scan and pass through S_WRITE
// and S_RESP. The input is ready again the cycle after the last result
// transfer of an item. Data and tag memories need no clearing; only the valid
// bits reset. One item is handled at a time.
module lru_block_cache_top #(
  parameter int unsigned ENTRIES     = 64,
  parameter int unsigned BLOCK_WORDS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  device_id_i,
  input  logic [15:0] sector_num_i,
  input  logic [15:0] block_num_i,
  input  logic [4:0]  word_index_i,
  input  logic [63:0] word_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [63:0] read_data_o,
  output logic        last_word_o,
  output logic [31:0] hit_total_o,
  output logic [31:0] miss_total_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned WW = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_SCAN = 7'b0000010, S_ALLOC = 7'b0000100,
    S_WRITE = 7'b0001000, S_RESP = 7'b0010000, S_STREAM = 7'b0100000,
    S_WAIT = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [6:0]   eiu_q;
  logic [IW:0]  limit;
  logic         kind_q;
  logic [39:0]  key_q;
  logic [4:0]   widx_q;
  logic [WW-1:0] widx_w;
  logic [63:0]  wdata_q;
  logic [63:0]  clk_cnt_q;
  logic [IW-1:0] fill_q, hit_idx_q;
  logic [31:0]  hits_q, miss_q;
  logic [ENTRIES-1:0] valid_q;
  logic [39:0]  tag_mem [ENTRIES];
  logic [63:0]  stamp_mem [ENTRIES];
  logic [63:0]  data_mem [ENTRIES << WW];
  logic [39:0]  tag_rd;
  logic [63:0]  stamp_rd, data_rd;
  logic         valid_rd;
  logic [IW-1:0] scan_addr, m_idx, f_idx, o_idx;
  logic         scan_busy, scan_done, m_found, f_found, scan_start;
  logic         stamp_we;
  logic [IW-1:0] stamp_idx;
  logic [WW:0]  wcnt_q;
  logic         ovalid_q, dvalid_q;
  logic [1:0]   ostat_q;
  logic         olast_q;
  logic         take;

  assign limit = (eiu_q == 7'd0) ? (IW+1)'(1) :
                 ({25'd0, eiu_q} > ENTRIES) ? (IW+1)'(ENTRIES) : (IW+1)'(eiu_q);
  assign widx_w = WW'(widx_q);

  lbc_scan #(.ENTRIES(ENTRIES), .IW(IW)) u_scan (
    .clk_i, .rst_ni, .start_i(scan_start), .limit_i(limit), .key_i(key_q),
    .ent_valid_i(valid_rd), .ent_tag_i(tag_rd), .ent_stamp_i(stamp_rd),
    .addr_o(scan_addr), .busy_o(scan_busy), .done_o(scan_done),
    .match_o(m_found), .match_idx_o(m_idx), .free_o(f_found),
    .free_idx_o(f_idx), .old_idx_o(o_idx));

  always_ff @(posedge clk_i) begin
    tag_rd   <= tag_mem[scan_addr];
    stamp_rd <= stamp_mem[scan_addr];
    valid_rd <= valid_q[scan_addr];
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign cfg_ready_o = 1'b1;
  assign scan_start  = in_ready_o && in_valid_i &&
                       (kind_i == lbc_pkg::KindLookup || word_index_i == 5'd0);

  logic [IW-1:0] slot;
  assign slot = m_found ? m_idx : (f_found ? f_idx : o_idx);
  assign stamp_we = (state_q == S_SCAN && scan_done &&
                     (kind_q == lbc_pkg::KindInsert || m_found));
  assign stamp_idx = (kind_q == lbc_pkg::KindInsert) ? slot : m_idx;
  assign take = !ovalid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (stamp_we) stamp_mem[stamp_idx] <= clk_cnt_q;
    if (stamp_we && kind_q == lbc_pkg::KindInsert) tag_mem[slot] <= key_q;
    if (state_q == S_WRITE && {27'd0, widx_q} < BLOCK_WORDS)
      data_mem[{fill_q, widx_w}] <= wdata_q;
    if (take) data_rd <= data_mem[{hit_idx_q, wcnt_q[WW-1:0]}];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = scan_start ? S_SCAN : S_WRITE;
      S_SCAN:  if (scan_done)
                 state_d = (kind_q == lbc_pkg::KindInsert) ? S_WRITE :
                           (m_found ? S_STREAM : S_RESP);
      S_ALLOC: state_d = S_WRITE;
      S_WRITE: state_d = S_RESP;
      S_RESP:  state_d = S_WAIT;
      S_STREAM: if (!ovalid_q || out_ready_i)
                  if (wcnt_q == (WW+1)'(BLOCK_WORDS)) state_d = S_WAIT;
      S_WAIT:  if (!ovalid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; eiu_q <= 7'd64; clk_cnt_q <= '0; fill_q <= '0;
      hits_q <= '0; miss_q <= '0; valid_q <= '0; ovalid_q <= 1'b0;
      wcnt_q <= '0; dvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) eiu_q <= cfg_data_i;
      if (stamp_we) clk_cnt_q <= clk_cnt_q + 64'd1;
      if (stamp_we && kind_q == lbc_pkg::KindInsert) begin
        valid_q[slot] <= 1'b1; fill_q <= slot;
      end
      if (state_q == S_SCAN && scan_done && kind_q == lbc_pkg::KindLookup) begin
        if (m_found) begin
          if (hits_q != 32'hFFFF_FFFF) hits_q <= hits_q + 32'd1;
        end else if (miss_q != 32'hFFFF_FFFF) miss_q <= miss_q + 32'd1;
        wcnt_q <= '0; dvalid_q <= 1'b0;
      end
      if ((state_q == S_RESP && take) || (state_q == S_STREAM && take && dvalid_q))
        ovalid_q <= 1'b1;
      else if (out_valid_o && out_ready_i) ovalid_q <= 1'b0;
      if (state_q == S_STREAM && take) begin
        if (wcnt_q != (WW+1)'(BLOCK_WORDS)) begin
          wcnt_q <= wcnt_q + 1'b1; dvalid_q <= 1'b1;
        end else dvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      kind_q <= kind_i; key_q <= {device_id_i, sector_num_i, block_num_i};
      widx_q <= word_index_i; wdata_q <= word_data_i;
    end
    if (state_q == S_SCAN && scan_done) hit_idx_q <= m_idx;
    if (state_q == S_RESP && take) begin
      ostat_q <= (kind_q == lbc_pkg::KindInsert) ? lbc_pkg::StatusInsert
                                                 : lbc_pkg::StatusMiss;
      read_data_o <= '0; olast_q <= 1'b1;
    end
    if (state_q == S_STREAM && take && dvalid_q) begin
      ostat_q <= lbc_pkg::StatusHit; read_data_o <= data_rd;
      olast_q <= (wcnt_q == (WW+1)'(BLOCK_WORDS));
    end
  end

  assign out_valid_o  = ovalid_q;
  assign status_o     = ostat_q;
  assign last_word_o  = olast_q;
  assign hit_total_o  = hits_q;
  assign miss_total_o = miss_q;

  a_one_hot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o))
    else $error("result dropped");
  a_no_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_busy |-> !in_ready_o) else $error("ready during scan");

endmodule
